// ===== rtl/core/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Opcode and status codes of the indexed list store, plus the empty-read value.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 11;
  localparam int unsigned ValueW  = 32;

  localparam logic [OpW-1:0] OP_READ = 3'd0;
  localparam logic [OpW-1:0] OP_HEAD = 3'd1;
  localparam logic [OpW-1:0] OP_TAIL = 3'd2;
  localparam logic [OpW-1:0] OP_AT   = 3'd3;
  localparam logic [OpW-1:0] OP_DEL  = 3'd4;

  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;

  localparam logic [ValueW-1:0] NO_VALUE = 32'hFFFF_FFFF;

endpackage

// ===== rtl/core/ils_ram.sv =====
// ----------------------------------------------------------------------------
// ils_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/indexed_list_store_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store_top
// Ordered list of signed 32-bit values kept in one RAM, addressed by position.
// ----------------------------------------------------------------------------
// One transfer in gives one result transfer out. Entries live in a single RAM
// with one write and one registered read port; the block works on one item at
// a time. A read within the list finishes in S_READ; inserts at the tail,
// deletes of the last entry, out-of-range or full cases and unused opcodes
// finish in the accept cycle. Inserting at position p into a list of n entries
// moves the n-p later entries up in S_UP, then writes the new item in S_PUT.
// Deleting at p moves the n-p-1 later entries down in S_DN. The worst case is
// an insert at the head of a list of CAPACITY-1 entries. The result sits in an
// output register, so the next item is taken as soon as that result is being
// transferred. No clearing pass is needed after reset.
module indexed_list_store_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [10:0] position_i,
  input  logic signed [31:0] item_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]  status_o,
  output logic [10:0] length_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > ils_pkg::PosW) ? CntW : ils_pkg::PosW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UP,
    S_PUT,
    S_DN
  } state_e;

  state_e                        state_q, state_d;
  logic [CntW-1:0]               count_q, count_d;
  logic [AddrW-1:0]              ptr_q, ptr_d;
  logic [AddrW-1:0]              stop_q, stop_d;
  logic [ils_pkg::ValueW-1:0]    val_q, val_d;
  logic                          out_valid_q, out_valid_d;
  logic [ils_pkg::ValueW-1:0]    out_value_q, out_value_d;
  logic [ils_pkg::StatusW-1:0]   out_status_q, out_status_d;
  logic [ils_pkg::PosW-1:0]      out_length_q, out_length_d;

  logic                          ram_we, ram_re;
  logic [AddrW-1:0]              ram_waddr, ram_raddr;
  logic [ils_pkg::ValueW-1:0]    ram_wdata, ram_rdata;

  logic                          in_accept;
  logic                          fin;
  logic [ils_pkg::ValueW-1:0]    fin_value;
  logic [ils_pkg::StatusW-1:0]   fin_status;
  logic [CmpW-1:0]               pos_ext, count_ext, ins_pos;
  logic [AddrW-1:0]              last_addr;
  logic                          full;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pos_ext   = CmpW'(position_i);
  assign count_ext = CmpW'(count_q);
  assign last_addr = AddrW'(count_q - CntW'(1));
  assign full      = (count_q == CntW'(CAPACITY));

  always_comb begin
    case (opcode_i)
      ils_pkg::OP_HEAD: ins_pos = '0;
      ils_pkg::OP_TAIL: ins_pos = count_ext;
      default:          ins_pos = pos_ext;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    stop_d     = stop_q;
    val_d      = val_q;
    ram_we     = 1'b0;
    ram_waddr  = ptr_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = ptr_q;
    fin        = 1'b0;
    fin_value  = ils_pkg::NO_VALUE;
    fin_status = ils_pkg::ST_DONE;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode_i)
            ils_pkg::OP_READ: begin
              if (pos_ext < count_ext) begin
                ram_re    = 1'b1;
                ram_raddr = AddrW'(position_i);
                state_d   = S_READ;
              end else begin
                fin        = 1'b1;
                fin_status = ils_pkg::ST_RANGE;
              end
            end
            ils_pkg::OP_HEAD, ils_pkg::OP_TAIL, ils_pkg::OP_AT: begin
              if (ins_pos > count_ext) begin
                fin        = 1'b1;
                fin_status = ils_pkg::ST_RANGE;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ils_pkg::ST_FULL;
              end else if (ins_pos == count_ext) begin
                // append: no entries to move
                ram_we    = 1'b1;
                ram_waddr = AddrW'(ins_pos);
                ram_wdata = item_value_i;
                count_d   = count_q + CntW'(1);
                fin       = 1'b1;
              end else begin
                // start moving entries up from the tail
                ram_re    = 1'b1;
                ram_raddr = last_addr;
                ptr_d     = last_addr;
                stop_d    = AddrW'(ins_pos);
                val_d     = item_value_i;
                state_d   = S_UP;
              end
            end
            ils_pkg::OP_DEL: begin
              if (pos_ext >= count_ext) begin
                fin        = 1'b1;
                fin_status = ils_pkg::ST_RANGE;
              end else if (pos_ext == count_ext - CmpW'(1)) begin
                count_d = count_q - CntW'(1);
                fin     = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AddrW'(position_i) + AddrW'(1);
                ptr_d     = AddrW'(position_i) + AddrW'(1);
                state_d   = S_DN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin       = 1'b1;
        fin_value = ram_rdata;
        state_d   = S_IDLE;
      end
      S_UP: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q + AddrW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == stop_q) begin
          state_d = S_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q - AddrW'(1);
          ptr_d     = ptr_q - AddrW'(1);
        end
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = stop_q;
        ram_wdata = val_q;
        count_d   = count_q + CntW'(1);
        fin       = 1'b1;
        state_d   = S_IDLE;
      end
      S_DN: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_q - AddrW'(1);
        ram_wdata = ram_rdata;
        if (ptr_q == last_addr) begin
          count_d = count_q - CntW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q + AddrW'(1);
          ptr_d     = ptr_q + AddrW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: drop the held result once transferred, load on finish.
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_length_d = out_length_q;
    if (fin) begin
      out_valid_d  = 1'b1;
      out_value_d  = fin_value;
      out_status_d = fin_status;
      out_length_d = ils_pkg::PosW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q        <= ptr_d;
    stop_q       <= stop_d;
    val_q        <= val_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_length_q <= out_length_d;
  end

  ils_ram #(
    .WIDTH (ils_pkg::ValueW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;
  assign length_o     = out_length_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_count_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> out_valid_q)
    else $error("entry count changed without a result");

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && fin_status == ils_pkg::ST_FULL) |-> full)
    else $error("full status on a list with room");

endmodule
